// ===== hw/rtl/dma_ring_period_tracker_macros.svh =====
// Assertion macros shared by the ring period tracker RTL.
`ifndef DMA_RING_PERIOD_TRACKER_MACROS_SVH
`define DMA_RING_PERIOD_TRACKER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DRPT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DRPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/drpt_pkg.sv =====
// Package: request and result types and fixed constants of the ring period tracker.
`default_nettype none
package drpt_pkg;

  localparam int WORD_W  = 32;
  localparam int POS_W   = 16;
  localparam int PEND_W  = 16;
  localparam int TOTAL_W = 17;
  localparam int TIME_W  = 64;
  localparam int TMO_W   = 32;

  localparam logic [TMO_W-1:0]  TIMEOUT_RST = 32'd92879818;
  localparam logic [WORD_W-1:0] BUS_ERR_WORD = 32'hffff_ffff;

  // Request function codes
  localparam logic FUNC_START    = 1'b0;
  localparam logic FUNC_POSITION = 1'b1;

  typedef struct packed {
    logic              func;
    logic [WORD_W-1:0] position_word;
    logic [TIME_W-1:0] now_ns;
  } in_item_t;

  typedef struct packed {
    logic [1:0] periods;
    logic       fault;
  } out_item_t;

endpackage
`default_nettype wire

// ===== hw/rtl/drpt_eval.sv =====
// Evaluator: checks one request against the tracking state and forms result and next state.
`default_nettype none
module drpt_eval #(
  parameter int RING_FRAMES   = 4096,
  parameter int PERIOD_FRAMES = 1024,
  parameter int PERIOD_COUNT  = 4,
  parameter int FW            = $clog2(RING_FRAMES)
) (
  input  drpt_pkg::in_item_t          item,
  input  logic [FW-1:0]               last_frame,
  input  logic [drpt_pkg::PEND_W-1:0] pending_frames,
  input  logic [drpt_pkg::TIME_W-1:0] last_time_ns,
  input  logic [drpt_pkg::TMO_W-1:0]  ring_timeout_ns,
  output drpt_pkg::out_item_t         result,
  output logic                        update,
  output logic [FW-1:0]               last_frame_nxt,
  output logic [drpt_pkg::PEND_W-1:0] pending_frames_nxt,
  output logic [drpt_pkg::TIME_W-1:0] last_time_ns_nxt
);
  import drpt_pkg::*;

  localparam int CNT_W = $clog2(PERIOD_COUNT + 1);

  logic [POS_W-1:0]   frame;
  logic [POS_W-1:0]   size_field;
  logic [TIME_W:0]    time_diff;
  logic               backwards;
  logic               stall;
  logic               bad_word;
  logic [FW:0]        adv_raw;
  logic [FW-1:0]      advanced;
  logic [TOTAL_W-1:0] total;
  logic [CNT_W-1:0]   count;
  logic [TOTAL_W-1:0] base;
  logic               count_bad;

  assign frame      = item.position_word[WORD_W-1:POS_W];
  assign size_field = item.position_word[POS_W-1:0];

  // Check elapsed time: borrow means time ran backwards
  assign time_diff = {1'b0, item.now_ns} - {1'b0, last_time_ns};
  assign backwards = time_diff[TIME_W];
  assign stall     = time_diff[TIME_W-1:0] >= {{(TIME_W-TMO_W){1'b0}}, ring_timeout_ns};

  assign bad_word = (item.position_word == BUS_ERR_WORD) ||
                    (frame >= POS_W'(RING_FRAMES)) ||
                    (size_field != POS_W'(RING_FRAMES - 1)) ||
                    backwards || stall;

  // Advance around the ring: one conditional subtract wraps the sum
  always_comb begin
    adv_raw = {1'b0, frame[FW-1:0]} + (FW+1)'(RING_FRAMES) - {1'b0, last_frame};
    if (adv_raw >= (FW+1)'(RING_FRAMES)) begin
      adv_raw = adv_raw - (FW+1)'(RING_FRAMES);
    end
    advanced = adv_raw[FW-1:0];
  end

  assign total = {1'b0, pending_frames} + TOTAL_W'(advanced);

  // Count whole periods against constant thresholds
  always_comb begin
    count = '0;
    base  = '0;
    for (int k = 1; k <= PERIOD_COUNT; k++) begin
      if (32'(total) >= 32'(k * PERIOD_FRAMES)) begin
        count = CNT_W'(k);
        base  = TOTAL_W'(k * PERIOD_FRAMES);
      end
    end
  end

  assign count_bad = (advanced == '0) || (count == '0) || (count >= CNT_W'(PERIOD_COUNT));

  // Form the result and the next tracking state
  always_comb begin
    result             = '0;
    update             = 1'b0;
    last_frame_nxt     = last_frame;
    pending_frames_nxt = pending_frames;
    last_time_ns_nxt   = last_time_ns;
    if (item.func == FUNC_START) begin
      update             = 1'b1;
      last_frame_nxt     = '0;
      pending_frames_nxt = '0;
      last_time_ns_nxt   = item.now_ns;
    end else if (bad_word || count_bad) begin
      result.fault = 1'b1;
    end else begin
      update             = 1'b1;
      result.periods     = count[1:0];
      last_frame_nxt     = frame[FW-1:0];
      pending_frames_nxt = PEND_W'(total - base);
      last_time_ns_nxt   = item.now_ns;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/dma_ring_period_tracker.sv =====
// An accepted request passes the request register, then the result register. One request per
// cycle while out_stall is low; state feedback closes in the single evaluation stage.
// in_stall rises only while the result register is held by out_stall.
// Reset (synchronous, rst_n low): tracking state clears, timeout returns to 92879818 ns.
// No clearing pass: the block accepts requests as soon as reset is released.
`default_nettype none
`include "dma_ring_period_tracker_macros.svh"
module dma_ring_period_tracker #(
  parameter int RING_FRAMES   = 4096,
  parameter int PERIOD_FRAMES = 1024,
  parameter int PERIOD_COUNT  = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  drpt_pkg::in_item_t         in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output drpt_pkg::out_item_t        out_item,
  input  logic                       cfg_we,
  input  logic [drpt_pkg::TMO_W-1:0] cfg_wdata
);
  import drpt_pkg::*;

  localparam int FW = $clog2(RING_FRAMES);

  logic              req_valid_r;
  in_item_t          req_r;
  logic              out_valid_r;
  out_item_t         out_item_r;
  logic [TMO_W-1:0]  timeout_r;
  logic [FW-1:0]     last_frame_r;
  logic [PEND_W-1:0] pending_r;
  logic [TIME_W-1:0] last_time_r;

  logic              out_open;
  logic              step;
  out_item_t         result;
  logic              update;
  logic [FW-1:0]     last_frame_nxt;
  logic [PEND_W-1:0] pending_nxt;
  logic [TIME_W-1:0] last_time_nxt;

  assign out_open = !out_valid_r || !out_stall;
  assign step     = req_valid_r && out_open;
  assign in_stall = req_valid_r && !out_open;

  // Capture the request while the evaluation stage can drain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (!in_stall) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_r <= in_item;
    end
  end

  drpt_eval #(
    .RING_FRAMES   (RING_FRAMES),
    .PERIOD_FRAMES (PERIOD_FRAMES),
    .PERIOD_COUNT  (PERIOD_COUNT),
    .FW            (FW)
  ) u_eval (
    .item               (req_r),
    .last_frame         (last_frame_r),
    .pending_frames     (pending_r),
    .last_time_ns       (last_time_r),
    .ring_timeout_ns    (timeout_r),
    .result             (result),
    .update             (update),
    .last_frame_nxt     (last_frame_nxt),
    .pending_frames_nxt (pending_nxt),
    .last_time_ns_nxt   (last_time_nxt)
  );

  // Advance tracking state when a request is evaluated
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_frame_r <= '0;
      pending_r    <= '0;
      last_time_r  <= '0;
    end else if (step && update) begin
      last_frame_r <= last_frame_nxt;
      pending_r    <= pending_nxt;
      last_time_r  <= last_time_nxt;
    end
  end

  // Hold the timeout register; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  // Result register: load on step, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_open) begin
      out_valid_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Checks
  `DRPT_ASSERT_NOW(a_fault_no_periods, clk, rst_n, out_valid_r && out_item_r.fault,
    out_item_r.periods == 2'd0, "faulted result carries a period count")
  `DRPT_ASSERT_NEXT(a_fault_keeps_state, clk, rst_n, step && result.fault,
    $stable(last_time_r) && $stable(pending_r) && $stable(last_frame_r),
    "faulted request changed tracking state")
  `DRPT_ASSERT_NOW(a_pending_below_period, clk, rst_n, 1'b1,
    {1'b0, pending_r} < (PEND_W+1)'(PERIOD_FRAMES), "pending frames reached a whole period")
  `DRPT_ASSERT_NOW(a_frame_in_ring, clk, rst_n, 1'b1,
    {1'b0, last_frame_r} < (FW+1)'(RING_FRAMES), "stored frame outside the ring")

endmodule
`default_nettype wire
